/* hdl/pdp_pkg.sv */
// Package: shared types, states and constants of the photon direction pairing block.
package pdp_pkg;

  localparam int unsigned MaxRecordsDef  = 64;
  localparam int unsigned OutFracBitsDef = 14;

  typedef struct packed {
    logic        valid;
    logic        found;
    logic [31:0] prev_id;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } pdp_tok_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_READ,
    ST_ISSUE,
    ST_SCAN,
    ST_NORM,
    ST_PUSH,
    ST_FLUSH
  } pdp_state_e;

  typedef enum logic [2:0] {
    NS_IDLE,
    NS_SCALE,
    NS_SQ,
    NS_SQRT,
    NS_DIV
  } pdp_nstate_e;

endpackage

/* hdl/pdp_cell.sv */
// One record cell of the id search chain; a query token passes through each cycle.
module pdp_cell
  import pdp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        we_i,
  input  logic        live_i,
  input  logic [31:0] id_i,
  input  logic [31:0] x_i,
  input  logic [31:0] y_i,
  input  logic [31:0] z_i,
  input  pdp_tok_t    tok_i,
  output pdp_tok_t    tok_o
);

  logic [31:0] id_q, x_q, y_q, z_q;
  pdp_tok_t    tok_d, tok_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      id_q <= id_i;
      x_q  <= x_i;
      y_q  <= y_i;
      z_q  <= z_i;
    end
  end

  always_comb begin
    tok_d = tok_i;
    if (tok_i.valid && !tok_i.found && live_i && (id_q == tok_i.prev_id)) begin
      tok_d.found = 1'b1;
      tok_d.x     = x_q;
      tok_d.y     = y_q;
      tok_d.z     = z_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

/* hdl/pdp_norm.sv */
// Iterative unit-vector unit: scale, sum of squares, square root, three divisions.
module pdp_norm
  import pdp_pkg::*;
#(
  parameter int unsigned OUT_FRAC_BITS = OutFracBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [32:0] dx_i,
  input  logic signed [32:0] dy_i,
  input  logic signed [32:0] dz_i,
  output logic               done_o,
  output logic               zero_o,
  output logic signed [15:0] cx_o,
  output logic signed [15:0] cy_o,
  output logic signed [15:0] cz_o
);

  localparam int unsigned QW = OUT_FRAC_BITS + 1;
  localparam int unsigned NW = OUT_FRAC_BITS + 32;
  localparam int unsigned CW = $clog2(QW + 1);

  pdp_nstate_e state_q, state_d;

  logic [31:0]   a_q [3];
  logic [2:0]    neg_q;
  logic [1:0]    cnt_q;
  logic [61:0]   prod_q;
  logic [63:0]   acc_q, s_q, res_q, bit_q;
  logic [31:0]   rem_q;
  logic [QW-1:0] qs_q;
  logic [CW-1:0] qc_q;
  logic [15:0]   c_q [3];
  logic          done_q, zero_q;

  logic [31:0]   m01, m;
  logic [31:0]   asel;
  logic [63:0]   rb;
  logic [31:0]   r;
  logic [NW-1:0] num;
  logic [32:0]   rem2;
  logic          ge;
  logic [31:0]   rem_n;
  logic [QW-1:0] qs_n;
  logic [32:0]   mag;
  logic [16:0]   mag_n, mag_p;
  logic [15:0]   csat;
  logic          last_step;

  assign m01  = (a_q[0] > a_q[1]) ? a_q[0] : a_q[1];
  assign m    = (m01 > a_q[2]) ? m01 : a_q[2];
  assign asel = (cnt_q == 2'd0) ? a_q[0] : (cnt_q == 2'd1) ? a_q[1] : a_q[2];
  assign rb   = res_q + bit_q;
  assign r    = res_q[31:0];
  assign num  = (NW'(asel[30:0]) << OUT_FRAC_BITS) + NW'(r[31:1]);
  assign rem2 = {rem_q, qs_q[QW-1]};
  assign ge   = rem2 >= {1'b0, r};
  assign rem_n = ge ? 32'(rem2 - {1'b0, r}) : rem2[31:0];
  assign qs_n = {qs_q[QW-2:0], ge};
  assign mag  = 33'(qs_n);
  assign mag_n = (mag > 33'd32768) ? 17'd32768 : mag[16:0];
  assign mag_p = (mag > 33'd32767) ? 17'd32767 : mag[16:0];
  assign last_step = (qc_q == CW'(QW));

  always_comb begin
    if (neg_q[cnt_q]) begin
      csat = 16'(17'h10000 - mag_n);
    end else begin
      csat = mag_p[15:0];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      NS_IDLE:  if (start_i) state_d = NS_SCALE;
      NS_SCALE: begin
        if (m == 32'd0) state_d = NS_IDLE;
        else if (m[31] || m[30]) state_d = NS_SQ;
      end
      NS_SQ:    if (cnt_q == 2'd3) state_d = NS_SQRT;
      NS_SQRT:  if (bit_q[0]) state_d = NS_DIV;
      NS_DIV:   if (last_step && cnt_q == 2'd2) state_d = NS_IDLE;
      default:  state_d = NS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= NS_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= ((state_q == NS_SCALE) && (m == 32'd0)) ||
                 ((state_q == NS_DIV) && last_step && (cnt_q == 2'd2));
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      NS_IDLE: begin
        if (start_i) begin
          neg_q  <= {dz_i[32], dy_i[32], dx_i[32]};
          a_q[0] <= dx_i[32] ? 32'(-dx_i) : dx_i[31:0];
          a_q[1] <= dy_i[32] ? 32'(-dy_i) : dy_i[31:0];
          a_q[2] <= dz_i[32] ? 32'(-dz_i) : dz_i[31:0];
        end
        cnt_q <= 2'd0;
        acc_q <= 64'd0;
      end
      NS_SCALE: begin
        zero_q <= (m == 32'd0);
        if (m[31]) begin
          for (int k = 0; k < 3; k++) a_q[k] <= a_q[k] >> 1;
        end else if (!m[30] && (m != 32'd0)) begin
          for (int k = 0; k < 3; k++) a_q[k] <= a_q[k] << 1;
        end
      end
      NS_SQ: begin
        if (cnt_q != 2'd3) prod_q <= asel[30:0] * asel[30:0];
        if (cnt_q != 2'd0) acc_q <= acc_q + 64'(prod_q);
        if (cnt_q == 2'd3) begin
          s_q   <= acc_q + 64'(prod_q);
          res_q <= 64'd0;
          bit_q <= 64'd1 << 62;
          cnt_q <= 2'd0;
          qc_q  <= '0;
        end else begin
          cnt_q <= cnt_q + 2'd1;
        end
      end
      NS_SQRT: begin
        if (s_q >= rb) begin
          s_q   <= s_q - rb;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      NS_DIV: begin
        if (qc_q == '0) begin
          rem_q <= 32'(num[NW-1:QW]);
          qs_q  <= num[QW-1:0];
          qc_q  <= CW'(1);
        end else begin
          rem_q <= rem_n;
          qs_q  <= qs_n;
          if (last_step) begin
            c_q[cnt_q] <= csat;
            cnt_q      <= cnt_q + 2'd1;
            qc_q       <= '0;
          end else begin
            qc_q <= qc_q + CW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign zero_o = zero_q;
  assign cx_o   = c_q[0];
  assign cy_o   = c_q[1];
  assign cz_o   = c_q[2];

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == NS_IDLE) else $error("start while busy");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> state_q == NS_IDLE) else $error("done while busy");
  a_scale_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == NS_SQRT |-> !a_q[0][31] && !a_q[1][31] && !a_q[2][31])
    else $error("scaled magnitude out of range");

endmodule

/* hdl/photon_direction_pairing.sv */
// Top level: record store, cell chain id search, sequencer and output stage.
// Records load at one per cycle while the block is in its load phase; the final
// record starts evaluation and in_stall_o stays high until the last result of the
// set has entered the output register. Each stored record is read from the store and,
// unless its previous id is zero, has its token pass the search chain; a match then
// goes through scaling, sum of squares, square root and division in the shared
// unit-vector unit (a zero difference stops after scaling and is not pushed); the
// unit reports done and the result is then pushed to the output stage.
module photon_direction_pairing
  import pdp_pkg::*;
#(
  parameter int unsigned MAX_RECORDS   = MaxRecordsDef,
  parameter int unsigned OUT_FRAC_BITS = OutFracBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] record_id_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic [31:0] previous_id_i,
  input  logic        last_record_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [15:0] dir_x_o,
  output logic signed [15:0] dir_y_o,
  output logic signed [15:0] dir_z_o,
  output logic        empty_set_o,
  output logic        records_dropped_o,
  output logic        last_direction_o
);

  localparam int unsigned AW = $clog2(MAX_RECORDS);
  localparam int unsigned CW = $clog2(MAX_RECORDS + 1);

  pdp_state_e state_q, state_d;

  logic [CW-1:0] count_q, idx_q;
  logic          ovf_q;
  logic [31:0]   mem_prev [MAX_RECORDS];
  logic [31:0]   mem_x    [MAX_RECORDS];
  logic [31:0]   mem_y    [MAX_RECORDS];
  logic [31:0]   mem_z    [MAX_RECORDS];
  logic [31:0]   rd_prev_q, rd_x_q, rd_y_q, rd_z_q;

  pdp_tok_t tok [MAX_RECORDS + 1];

  logic        accept, wr_en, full;
  logic        inject, norm_start, adv, out_free, out_load, pend_load;
  logic        norm_done, norm_zero;
  logic signed [15:0] cx, cy, cz;
  logic signed [32:0] dx, dy, dz;

  logic        pend_valid_q;
  logic [15:0] pend_x_q, pend_y_q, pend_z_q;
  logic        out_valid_q, out_empty_q, out_drop_q, out_last_q;
  logic [15:0] out_x_q, out_y_q, out_z_q;

  assign full     = (count_q == CW'(MAX_RECORDS));
  assign accept   = in_valid_i && !in_stall_o;
  assign wr_en    = accept && !full;
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_prev[count_q[AW-1:0]] <= previous_id_i;
      mem_x[count_q[AW-1:0]]    <= pos_x_i;
      mem_y[count_q[AW-1:0]]    <= pos_y_i;
      mem_z[count_q[AW-1:0]]    <= pos_z_i;
    end
    if (state_q == ST_READ) begin
      rd_prev_q <= mem_prev[idx_q[AW-1:0]];
      rd_x_q    <= mem_x[idx_q[AW-1:0]];
      rd_y_q    <= mem_y[idx_q[AW-1:0]];
      rd_z_q    <= mem_z[idx_q[AW-1:0]];
    end
  end

  always_comb begin
    tok[0]         = '0;
    tok[0].valid   = inject;
    tok[0].prev_id = rd_prev_q;
  end

  for (genvar k = 0; k < MAX_RECORDS; k++) begin : g_cell
    pdp_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .we_i   (wr_en && (count_q[AW-1:0] == AW'(k))),
      .live_i (count_q > CW'(k)),
      .id_i   (record_id_i),
      .x_i    (pos_x_i),
      .y_i    (pos_y_i),
      .z_i    (pos_z_i),
      .tok_i  (tok[k]),
      .tok_o  (tok[k+1])
    );
  end

  assign dx = $signed({tok[MAX_RECORDS].x[31], tok[MAX_RECORDS].x}) -
              $signed({rd_x_q[31], rd_x_q});
  assign dy = $signed({tok[MAX_RECORDS].y[31], tok[MAX_RECORDS].y}) -
              $signed({rd_y_q[31], rd_y_q});
  assign dz = $signed({tok[MAX_RECORDS].z[31], tok[MAX_RECORDS].z}) -
              $signed({rd_z_q[31], rd_z_q});

  pdp_norm #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (norm_start),
    .dx_i    (dx),
    .dy_i    (dy),
    .dz_i    (dz),
    .done_o  (norm_done),
    .zero_o  (norm_zero),
    .cx_o    (cx),
    .cy_o    (cy),
    .cz_o    (cz)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD:  if (accept && last_record_i) state_d = ST_READ;
      ST_READ:  state_d = (idx_q == count_q) ? ST_FLUSH : ST_ISSUE;
      ST_ISSUE: state_d = (rd_prev_q == 32'd0) ? ST_READ : ST_SCAN;
      ST_SCAN: begin
        if (tok[MAX_RECORDS].valid) begin
          state_d = tok[MAX_RECORDS].found ? ST_NORM : ST_READ;
        end
      end
      ST_NORM:  if (norm_done) state_d = norm_zero ? ST_READ : ST_PUSH;
      ST_PUSH:  if (!pend_valid_q || out_free) state_d = ST_READ;
      ST_FLUSH: if (out_free) state_d = ST_LOAD;
      default:  state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != ST_LOAD);
    inject     = (state_q == ST_ISSUE) && (rd_prev_q != 32'd0);
    norm_start = (state_q == ST_SCAN) && tok[MAX_RECORDS].valid && tok[MAX_RECORDS].found;
    pend_load  = (state_q == ST_PUSH) && (!pend_valid_q || out_free);
    out_load   = ((state_q == ST_PUSH) && pend_valid_q && out_free) ||
                 ((state_q == ST_FLUSH) && out_free);
    adv        = ((state_q == ST_ISSUE) && (rd_prev_q == 32'd0)) ||
                 ((state_q == ST_SCAN) && tok[MAX_RECORDS].valid && !tok[MAX_RECORDS].found) ||
                 ((state_q == ST_NORM) && norm_done && norm_zero) ||
                 pend_load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_LOAD;
      count_q      <= '0;
      idx_q        <= '0;
      ovf_q        <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (wr_en) count_q <= count_q + CW'(1);
      if (accept && full) ovf_q <= 1'b1;
      if (state_q == ST_LOAD) idx_q <= '0;
      else if (adv) idx_q <= idx_q + CW'(1);
      if (pend_load) pend_valid_q <= 1'b1;
      if ((state_q == ST_FLUSH) && out_free) begin
        pend_valid_q <= 1'b0;
        count_q      <= '0;
        idx_q        <= '0;
        ovf_q        <= 1'b0;
      end
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_load) begin
      pend_x_q <= cx;
      pend_y_q <= cy;
      pend_z_q <= cz;
    end
    if (out_load) begin
      out_drop_q  <= ovf_q;
      out_last_q  <= (state_q == ST_FLUSH);
      out_empty_q <= !pend_valid_q;
      out_x_q     <= pend_valid_q ? pend_x_q : 16'd0;
      out_y_q     <= pend_valid_q ? pend_y_q : 16'd0;
      out_z_q     <= pend_valid_q ? pend_z_q : 16'd0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign dir_x_o           = out_x_q;
  assign dir_y_o           = out_y_q;
  assign dir_z_o           = out_z_q;
  assign empty_set_o       = out_empty_q;
  assign records_dropped_o = out_drop_q;
  assign last_direction_o  = out_last_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_RECORDS)) else $error("record count overflow");
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= count_q) else $error("sequencer index past count");
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && empty_set_o |-> last_direction_o && dir_x_o == 16'd0 &&
    dir_y_o == 16'd0 && dir_z_o == 16'd0) else $error("bad empty result");
  a_norm_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    norm_done |-> state_q == ST_NORM) else $error("unexpected norm done");

endmodule
